### hdl/salct_pkg.sv
// Shared types and constants for the set-associative LRU cache tag array.
// No dependencies; imported by salct_back and the top module.
package salct_pkg;
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_FILL   = 2'd1;
	localparam logic [1:0] MODE_INVAL  = 2'd2;
	localparam logic [1:0] MODE_PROBE  = 2'd3;
	localparam int ADDR_W = 64;
	localparam int REQ_W  = 16;
	localparam int LINE_W = 58;
	localparam int OFF_W  = 6;

	typedef struct packed {
		logic              hit;
		logic              evict_valid;
		logic              evict_dirty;
		logic [LINE_W-1:0] evict_line_addr;
		logic [OFF_W-1:0]  evict_offset;
		logic [REQ_W-1:0]  evict_requester;
	} result_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] address;
		logic [REQ_W-1:0]  requester;
		logic              is_load;
	} req_t;
endpackage

### hdl/salct_fifo.sv
// Small synchronous queue with full/empty flags.
// Depends on nothing but its parameters; used as the input and output queues of the back end.
module salct_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule

### hdl/salct_back.sv
// Back end: per-set tag/state memories, LRU update and result generation.
// Depends on salct_pkg; consumes decoded requests, emits result_t.
module salct_back #(
	parameter int LINE_BYTES = 64,
	parameter int NUM_SETS   = 64,
	parameter int NUM_WAYS   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  salct_pkg::req_t     req,
	input  logic                req_empty,
	output logic                req_pop,
	output salct_pkg::result_t  res,
	output logic                res_push,
	input  logic                res_full
);
	import salct_pkg::*;
	localparam int OB   = $clog2(LINE_BYTES);
	localparam int SB   = $clog2(NUM_SETS);
	localparam int SW   = (SB > 0) ? SB : 1;
	localparam int TAGW = ADDR_W - OB - SB;
	localparam int WB   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int SETS = NUM_SETS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_CLR  = 2'd3;

	typedef struct packed {
		logic [TAGW-1:0]  tag;
		logic [OFF_W-1:0] off;
		logic [REQ_W-1:0] rq;
		logic [WB-1:0]    rank;
		logic             valid;
		logic             dirty;
	} way_t;

	way_t set_mem [SETS][NUM_WAYS];
	way_t row_q [NUM_WAYS];
	logic [1:0] state_q;
	logic [SW-1:0] clr_q;
	req_t cur_q;

	logic [TAGW-1:0] tag;
	logic [SW-1:0]   set;
	logic [OFF_W-1:0] off;
	logic [NUM_WAYS-1:0] match, freev, oldest;
	logic found, anyfree;
	logic [WB-1:0] hw, fw, ow, way;
	way_t row_n [NUM_WAYS];
	result_t r;
	logic wr;

	assign tag = TAGW'(cur_q.address >> (OB + SB));
	assign set = (SB > 0) ? SW'(cur_q.address >> OB) : '0;
	assign off = OFF_W'(cur_q.address & ADDR_W'(LINE_BYTES-1));

	always_comb begin
		found = 1'b0; anyfree = 1'b0;
		hw = '0; fw = '0; ow = '0;
		for (int w = NUM_WAYS-1; w >= 0; w--) begin
			match[w]  = row_q[w].valid && (row_q[w].tag == tag);
			freev[w]  = !row_q[w].valid;
			oldest[w] = (row_q[w].rank == WB'(NUM_WAYS-1));
			if (match[w]) begin found = 1'b1; hw = WB'(w); end
			if (freev[w]) begin anyfree = 1'b1; fw = WB'(w); end
			if (oldest[w]) ow = WB'(w);
		end
		way = found ? hw : (anyfree ? fw : ow);
		r = '0;
		wr = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) row_n[w] = row_q[w];
		case (cur_q.mode)
			MODE_LOOKUP: begin
				if (found) begin
					r.hit = 1'b1;
					wr = 1'b1;
				end
			end
			MODE_FILL: begin
				wr = 1'b1;
				if (!found && !anyfree) begin
					r.evict_valid     = 1'b1;
					r.evict_dirty     = row_q[ow].dirty;
					r.evict_line_addr = LINE_W'(({64'd0, row_q[ow].tag} << SB)
						| (ADDR_W+TAGW)'(set));
					r.evict_offset    = row_q[ow].off;
					r.evict_requester = row_q[ow].rq;
				end
			end
			MODE_INVAL: begin
				if (found) begin
					r.evict_valid     = 1'b1;
					r.evict_dirty     = row_q[hw].dirty;
					r.evict_line_addr = LINE_W'(({64'd0, tag} << SB)
						| (ADDR_W+TAGW)'(set));
					r.evict_offset    = row_q[hw].off;
					r.evict_requester = row_q[hw].rq;
					row_n[hw].valid = 1'b0;
					row_n[hw].dirty = 1'b0;
					wr = 1'b1;
				end
			end
			MODE_PROBE: r.hit = found;
			default: r = '0;
		endcase
		if (wr && cur_q.mode != MODE_INVAL) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (row_q[w].rank < row_q[way].rank) row_n[w].rank = row_q[w].rank + 1'b1;
			end
			row_n[way].rank = '0;
			row_n[way].off  = off;
			row_n[way].rq   = cur_q.requester;
			if (cur_q.mode == MODE_FILL) begin
				row_n[way].tag   = tag;
				row_n[way].valid = 1'b1;
				row_n[way].dirty = !cur_q.is_load;
			end else if (!cur_q.is_load) begin
				row_n[way].dirty = 1'b1;
			end
		end
	end

	assign req_pop  = (state_q == ST_IDLE) && !req_empty;
	assign res      = r;
	assign res_push = (state_q == ST_EXEC) && !res_full;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				set_mem[clr_q][w] <= '{tag: '0, off: '0, rq: '0,
					rank: WB'(w), valid: 1'b0, dirty: 1'b0};
			end
		end else if (res_push && wr) begin
			for (int w = 0; w < NUM_WAYS; w++) set_mem[set][w] <= row_n[w];
		end
		if (state_q == ST_READ) begin
			for (int w = 0; w < NUM_WAYS; w++) row_q[w] <= set_mem[set][w];
		end
		if (req_pop) cur_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(SETS-1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (!req_empty) state_q <= ST_READ;
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: if (!res_full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hdl/set_assoc_lru_cache_tags.sv
// Set-associative write-back cache tag array with true LRU per set.
// Items pass through an input queue, the back end and an output queue; the back end takes a new
// item only after it has finished the read-modify-write of one set row.
// Reset: asynchronous; after reset a clearing pass over all NUM_SETS sets initialises ranks
// and valid bits, during which queued items wait.
// Depends on salct_pkg, salct_fifo, salct_back.
module set_assoc_lru_cache_tags #(
	parameter int LINE_BYTES = 64,
	parameter int NUM_SETS   = 64,
	parameter int NUM_WAYS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [63:0] address,
	input  logic [15:0] requester,
	input  logic        is_load,
	output logic        empty,
	input  logic        pop,
	output logic        hit,
	output logic        evict_valid,
	output logic        evict_dirty,
	output logic [57:0] evict_line_addr,
	output logic [5:0]  evict_offset,
	output logic [15:0] evict_requester
);
	import salct_pkg::*;
	req_t in_d, q_d;
	logic q_empty, q_pop, r_push, r_full;
	result_t r_d, o_d;

	assign in_d = '{mode: mode, address: address, requester: requester, is_load: is_load};

	salct_fifo #(.WIDTH($bits(req_t)), .DEPTH(2)) u_inq (
		.clk, .arst_n, .push, .wdata(in_d), .full,
		.pop(q_pop), .rdata(q_d), .empty(q_empty));

	salct_back #(.LINE_BYTES(LINE_BYTES), .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_back (
		.clk, .arst_n, .req(q_d), .req_empty(q_empty), .req_pop(q_pop),
		.res(r_d), .res_push(r_push), .res_full(r_full));

	salct_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_outq (
		.clk, .arst_n, .push(r_push), .wdata(r_d), .full(r_full),
		.pop, .rdata(o_d), .empty);

	assign hit             = o_d.hit;
	assign evict_valid     = o_d.evict_valid;
	assign evict_dirty     = o_d.evict_dirty;
	assign evict_line_addr = o_d.evict_line_addr;
	assign evict_offset    = o_d.evict_offset;
	assign evict_requester = o_d.evict_requester;
endmodule
